### hw/rtl/gbet_pkg.sv
// Shared types, constants and the button permutation for the gamepad edge translator.
// No dependencies; every other file imports this package.
package gbet_pkg;

    localparam int unsigned WORD_W = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CNT_W  = 3;

    localparam logic [BYTE_W-1:0] FMT_ANALOG_A  = 8'h73;
    localparam logic [BYTE_W-1:0] FMT_ANALOG_B  = 8'h53;
    localparam logic [CNT_W-1:0]  MISSING_LIMIT = 3'd6;
    localparam logic [BYTE_W-1:0] STICK_CENTER  = 8'h80;
    localparam logic [WORD_W-1:0] KEEP_MASK     = 16'h61F9;

    localparam logic [BYTE_W-1:0] DEADZONE_LOW_RST  = 8'd74;
    localparam logic [BYTE_W-1:0] DEADZONE_HIGH_RST = 8'd183;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_DEADZONE_LOW  = 1'b0,
        REG_DEADZONE_HIGH = 1'b1
    } reg_idx_t;

    // Raw bit position read for each map entry, and the logical bit it drives
    localparam logic [3:0] PAD_IDX [WORD_W] = '{
        4'd4,  4'd6,  4'd7,  4'd5,  4'd12, 4'd14, 4'd15, 4'd13,
        4'd10, 4'd8,  4'd11, 4'd9,  4'd1,  4'd2,  4'd3,  4'd0
    };
    localparam logic [3:0] LOGIC_IDX [WORD_W] = '{
        4'd0,  4'd1,  4'd2,  4'd3,  4'd4,  4'd7,  4'd5,  4'd6,
        4'd8,  4'd10, 4'd9,  4'd11, 4'd12, 4'd13, 4'd14, 4'd15
    };

    typedef struct packed {
        logic              link_valid;
        logic [WORD_W-1:0] raw_buttons;
        logic [BYTE_W-1:0] frame_format;
        logic [BYTE_W-1:0] stick_raw_x;
        logic [BYTE_W-1:0] stick_raw_y;
    } frame_t;

    typedef struct packed {
        logic [WORD_W-1:0]        held_mask;
        logic [WORD_W-1:0]        pressed_mask;
        logic [WORD_W-1:0]        released_mask;
        logic signed [BYTE_W-1:0] stick_x;
        logic signed [BYTE_W-1:0] stick_y;
        logic                     controller_missing;
    } result_t;

    typedef struct packed {
        logic [BYTE_W-1:0] deadzone_low;
        logic [BYTE_W-1:0] deadzone_high;
    } cfg_t;

    // Reorder the active-low word that follows a frame in the second analogue format
    function automatic logic [WORD_W-1:0] permute_word(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] r;
        a = ~w;
        r = ((a & 16'h0800) << 1) | ((a & 16'h0400) << 5) |
            ((a & 16'h0200) << 1) | ((a & 16'h8000) >> 6) |
            ((a & 16'h1000) >> 1) | (a & KEEP_MASK);
        return ~r;
    endfunction

endpackage

### hw/rtl/gbet_if.sv
// Valid/ready channel interfaces for controller frames and translated results.
// Depends on gbet_pkg for the payload types.
interface gbet_frame_if
    import gbet_pkg::*;
();
    logic   valid;
    logic   ready;
    frame_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gbet_result_if
    import gbet_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/gbet_frame_reg.sv
// Input register for controller frames; releases a slot whenever the held beat advances.
// Depends on gbet_pkg and gbet_frame_if.
module gbet_frame_reg
    import gbet_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    gbet_frame_if.sink    frame,
    input  logic          advance,
    output logic          item_valid,
    output frame_t        item
);

    logic   valid_reg;
    logic   valid_next;
    frame_t item_reg;
    logic   take;

    // Accept a new beat when empty or when the held one moves on
    assign frame.ready = !valid_reg || advance;
    assign take        = frame.valid && frame.ready;
    assign valid_next  = take || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= frame.data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### hw/rtl/gbet_xlate.sv
// Frame translation: button permutation and map, edge masks, stick centering, missing count.
// Holds the per-frame history; depends on gbet_pkg.
module gbet_xlate
    import gbet_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  frame_t  item,
    input  cfg_t    cfg,
    output result_t res
);

    logic [WORD_W-1:0] previous_word_reg;
    logic [WORD_W-1:0] previous_word_next;
    logic [BYTE_W-1:0] previous_format_reg;
    logic [BYTE_W-1:0] previous_format_next;
    logic [CNT_W-1:0]  missing_count_reg;
    logic [CNT_W-1:0]  missing_count_next;

    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] held;
    logic [WORD_W-1:0] pressed;
    logic [WORD_W-1:0] released;
    logic              analog;
    logic              x_inside;
    logic              y_inside;
    logic              show_stick;

    // Permute when the last valid frame used the second analogue format
    assign word = (previous_format_reg == FMT_ANALOG_B) ? permute_word(item.raw_buttons)
                                                        : item.raw_buttons;

    // Map raw bits to logical bits and compare against the stored word
    always_comb
    begin
        held     = '0;
        pressed  = '0;
        released = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            held[LOGIC_IDX[i]]     = !word[PAD_IDX[i]];
            pressed[LOGIC_IDX[i]]  = !word[PAD_IDX[i]] && previous_word_reg[PAD_IDX[i]];
            released[LOGIC_IDX[i]] = word[PAD_IDX[i]] && !previous_word_reg[PAD_IDX[i]];
        end
    end

    // Square deadzone test on both axes
    assign analog   = (item.frame_format == FMT_ANALOG_A) || (item.frame_format == FMT_ANALOG_B);
    assign x_inside = (item.stick_raw_x >= cfg.deadzone_low) &&
                      (item.stick_raw_x < cfg.deadzone_high);
    assign y_inside = (item.stick_raw_y >= cfg.deadzone_low) &&
                      (item.stick_raw_y < cfg.deadzone_high);
    assign show_stick = item.link_valid && analog && !(x_inside && y_inside);

    // Next history: keep on invalid frames, saturate the missing count
    always_comb
    begin
        previous_word_next   = previous_word_reg;
        previous_format_next = previous_format_reg;
        missing_count_next   = missing_count_reg;
        if (item.link_valid)
        begin
            previous_word_next   = word;
            previous_format_next = item.frame_format;
            missing_count_next   = '0;
        end
        else if (missing_count_reg < MISSING_LIMIT)
        begin
            missing_count_next = missing_count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_word_reg   <= '0;
            previous_format_reg <= '0;
            missing_count_reg   <= '0;
        end
        else if (advance)
        begin
            previous_word_reg   <= previous_word_next;
            previous_format_reg <= previous_format_next;
            missing_count_reg   <= missing_count_next;
        end
    end

    // Drive the result; zero everything but the flag on invalid frames
    always_comb
    begin
        res.held_mask          = item.link_valid ? held     : '0;
        res.pressed_mask       = item.link_valid ? pressed  : '0;
        res.released_mask      = item.link_valid ? released : '0;
        res.stick_x            = show_stick ? signed'(item.stick_raw_x ^ STICK_CENTER) : '0;
        res.stick_y            = show_stick ? signed'(item.stick_raw_y ^ STICK_CENTER) : '0;
        res.controller_missing = (missing_count_next >= MISSING_LIMIT);
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        missing_count_reg <= MISSING_LIMIT)
        else $error("missing count above its limit");

    a_valid_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.link_valid |=> missing_count_reg == '0)
        else $error("valid frame did not clear missing count");

    a_invalid_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !item.link_valid |=> $stable(previous_word_reg) && $stable(previous_format_reg))
        else $error("invalid frame changed history");

    a_edges_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> ((res.pressed_mask & ~res.held_mask) == '0) &&
                    ((res.released_mask & res.held_mask) == '0))
        else $error("edge masks disagree with held mask");

endmodule

### hw/rtl/gbet_result_reg.sv
// Result register: holds one translated beat until the sink takes it.
// Depends on gbet_pkg and gbet_result_if.
module gbet_result_reg
    import gbet_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  result_t        res,
    gbet_result_if.source  result,
    output logic           full
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // Hold until taken, refill on load
    assign valid_next = load || (valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign result.valid = valid_reg;
    assign result.data  = data_reg;
    assign full         = valid_reg;

endmodule

### hw/rtl/gamepad_button_edge_translator.sv
// Top level of the gamepad button edge translator: frame register, translation, result register.
// Depends on gbet_pkg, gbet_if, gbet_frame_reg, gbet_xlate and gbet_result_reg.
//
//   channel   dir  payload    beat
//   frame     in   frame_t    one controller frame
//   result    out  result_t   masks, centred stick, missing flag
//   cfg_*     in   8-bit data deadzone_low (0), deadzone_high (1)
//
// Each frame is registered, translated combinationally and written to the result register:
// result valid after frame and result registers; one frame per cycle unless result stalls.
// The result register frees the frame register, so one frame can wait there while a result waits.
// A stall on result backs up one stage at a time; frame.ready depends on result.ready.
// Reset clears history, the missing count and both stages; deadzone bounds return to defaults.
module gamepad_button_edge_translator
    import gbet_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    gbet_frame_if.sink          frame,
    gbet_result_if.source       result,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [BYTE_W-1:0]   cfg_wdata
);

    cfg_t    cfg_reg;
    logic    item_valid;
    frame_t  item;
    result_t res;
    logic    out_full;
    logic    advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadzone_low  <= DEADZONE_LOW_RST;
            cfg_reg.deadzone_high <= DEADZONE_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_DEADZONE_LOW:  cfg_reg.deadzone_low  <= cfg_wdata;
                REG_DEADZONE_HIGH: cfg_reg.deadzone_high <= cfg_wdata;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Advance the held frame when the result slot is free or draining
    assign advance = item_valid && (!out_full || result.ready);

    gbet_frame_reg u_frame_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame      (frame),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    gbet_xlate u_xlate (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .cfg     (cfg_reg),
        .res     (res)
    );

    gbet_result_reg u_result_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .res    (res),
        .result (result),
        .full   (out_full)
    );

endmodule
